@@ rtl/vftp_pkg.sv @@
// vftp_pkg: shared constants, types and helper functions of the field test pattern block
// no dependencies; imported by every module of the block

package vftp_pkg;

   localparam int XW = 12;
   localparam int YW = 11;
   localparam int PW = 4;
   localparam int WORD_W = 16;
   localparam int CSR_W = 13;
   localparam int CSR_AW = 1;
   localparam int THR_W = 13;
   localparam int QUO_W = 8;
   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS = QUO_W / DIV_STAGES;

   localparam logic [CSR_AW-1:0] REG_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_AW-1:0] REG_FIELD_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] FRAME_WIDTH_RST = 13'd1920;
   localparam logic [11:0] FIELD_HEIGHT_RST = 12'd540;

   localparam logic [WORD_W-1:0] PIX_BLACK = 16'h1080;
   localparam logic [WORD_W-1:0] PIX_LINE = 16'hE080;
   localparam logic [WORD_W-1:0] PIX_WHITE = 16'hF080;
   localparam logic [7:0] PIX_BARS_HI = 8'hC0;
   localparam logic [7:0] PIX_CHROMA = 8'h80;

   // floor(n/9) as (n*REC_M) >> REC_S, exact for n below 2^20/5
   localparam int REC_M = 116509;
   localparam int REC_S = 20;
   localparam int REC_PW = THR_W + 17;

   typedef struct packed {
      logic [THR_W-1:0] t3;
      logic [THR_W-1:0] t4;
      logic [THR_W-1:0] t5;
      logic [THR_W-1:0] t6;
      logic [THR_W-1:0] t8;
   } band_thr_type;

   // n/9 for n below 72
   function automatic logic [2:0] frac9(input logic [6:0] n);
      logic [12:0] p;
      p = 13'(n) * 13'd57;
      return 3'(p >> 9);
   endfunction

   // floor(k*h/9) from q = h/9 and r = h%9
   function automatic logic [THR_W-1:0] band_of(input logic [THR_W-1:0] q,
                                                input logic [3:0] r,
                                                input logic [3:0] k);
      logic [THR_W+3:0] kq;
      logic [6:0] kr;
      kq = (THR_W+4)'(q) * (THR_W+4)'(k);
      kr = 7'(r) * 7'(k);
      return THR_W'(kq + (THR_W+4)'(frac9(kr)));
   endfunction

endpackage

@@ rtl/video_field_test_pattern_top.sv @@
// video_field_test_pattern_top: pixel pattern pipeline of the field test pattern block
// depends on vftp_pkg, vftp_cfg and vftp_div
//
// channel   dir  handshake             payload
// req       in   req_tvalid/tready     tdata: pixel_x, pixel_y, field_phase
// rsp       out  rsp_tvalid/tready     tdata: pixel_word; tuser: in_frame
// csr       in   csr_we                csr_addr, csr_wdata
//
// one request per clock sustained while results are taken; a taken request passes through
// the input register, the four 2-bit divider stages for the bars and the output register
// synchronous reset empties the pipeline and loads 1920 x 540
// a result not taken holds every stage; req_tready drops in the same cycle
// band thresholds follow a csr write via the csr, reciprocal and threshold registers

module video_field_test_pattern_top import vftp_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_FIELD_HEIGHT = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // pixel_x[11:0], pixel_y[22:12], field_phase[26:23]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // pixel_word[15:0]
   output logic [0:0]        rsp_tuser,   // in_frame[0]
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);

   logic [WW-1:0]    width_sat;
   logic [THR_W-1:0] height_sat;
   band_thr_type     band_thr;
   logic             en;
   logic [QUO_W-1:0] bar_level;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [XW-1:0]    x1_ff;
   logic [YW-1:0]    y1_ff, y2_ff;
   logic [PW-1:0]    ph1_ff, ph2_ff;
   logic [7:0]       x2_ff;
   logic             inf2_in, left2_in, mid2_in;
   logic             inf2_ff, left2_ff, mid2_ff;
   logic [WW-1:0]    half;
   logic [WORD_W-1:0] word3_in, word3_ff, word4_ff, word5_ff, word6_in, word6_ff;
   logic             bars3_in, bars3_ff, bars4_ff, bars5_ff;
   logic             inf3_ff, inf4_ff, inf5_ff, inf6_ff;

   vftp_cfg #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_FIELD_HEIGHT(MAX_FIELD_HEIGHT),
      .WW(WW)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .width_sat(width_sat),
      .height_sat(height_sat),
      .band_thr(band_thr)
   );

   assign en = !v6_ff || rsp_tready;
   assign req_tready = en && !reset;

   vftp_div #(.WW(WW)) u_div (
      .clock(clock),
      .en(en),
      .num(WW'(x1_ff)),
      .den(width_sat),
      .quo(bar_level)
   );

   // frame check and half-line positions
   always_comb begin
      half = width_sat >> 1;
      inf2_in = (32'(x1_ff) < 32'(width_sat)) && (32'(y1_ff) < 32'(height_sat));
      left2_in = 32'(x1_ff) < 32'(half);
      mid2_in = !left2_in && (32'(x1_ff) < (32'(half) << 1));
   end

   // layer selection, highest priority first
   always_comb begin
      logic [THR_W-1:0] y;
      logic [3:0]       diag, horz;
      y = THR_W'(y2_ff);
      diag = 4'(x2_ff[3:0] + y2_ff[3:0] + ph2_ff);
      horz = 4'(y2_ff[3:0] + ph2_ff);
      bars3_in = 1'b0;
      word3_in = PIX_BLACK;
      priority if (y == '0) begin
         word3_in = (left2_ff ^ ph2_ff[0]) ? PIX_BLACK : PIX_WHITE;
      end else if (y == band_thr.t8 &&
                   ((!ph2_ff[0] && left2_ff) || (ph2_ff[0] && mid2_ff))) begin
         word3_in = PIX_BLACK;
      end else if (y >= band_thr.t5 && y < band_thr.t6) begin
         word3_in = (diag[3:1] == 3'd0) ? PIX_LINE : PIX_BLACK;
      end else if (y >= band_thr.t4 && y < band_thr.t5) begin
         word3_in = (horz == 4'd0) ? PIX_LINE : PIX_BLACK;
      end else if (y >= band_thr.t3 && y < band_thr.t4) begin
         word3_in = (x2_ff[3:1] == 3'd0) ? PIX_LINE : PIX_BLACK;
      end else if (y >= band_thr.t6) begin
         bars3_in = 1'b1;
      end else if (y < band_thr.t3) begin
         word3_in = {x2_ff, PIX_CHROMA};
      end else begin
         word3_in = PIX_BLACK;
      end
   end

   always_comb begin
      if (!inf5_ff) begin
         word6_in = PIX_BLACK;
      end else if (bars5_ff) begin
         word6_in = {PIX_BARS_HI, bar_level};
      end else begin
         word6_in = word5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_tdata[11:0];
         y1_ff <= req_tdata[22:12];
         ph1_ff <= req_tdata[26:23];
         x2_ff <= x1_ff[7:0];
         y2_ff <= y1_ff;
         ph2_ff <= ph1_ff;
         inf2_ff <= inf2_in;
         left2_ff <= left2_in;
         mid2_ff <= mid2_in;
         word3_ff <= word3_in;
         bars3_ff <= bars3_in;
         inf3_ff <= inf2_ff;
         word4_ff <= word3_ff;
         bars4_ff <= bars3_ff;
         inf4_ff <= inf3_ff;
         word5_ff <= word4_ff;
         bars5_ff <= bars4_ff;
         inf5_ff <= inf4_ff;
         word6_ff <= word6_in;
         inf6_ff <= inf5_ff;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata = word6_ff;
   assign rsp_tuser = inf6_ff;

   a_out_of_frame_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == PIX_BLACK)
      else $error("out-of-frame result is not black");

   a_no_take_while_blocked: assert property (@(posedge clock)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result is blocked");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

@@ rtl/vftp_cfg.sv @@
// vftp_cfg: width/height registers, saturation and band threshold pipeline
// depends on vftp_pkg

module vftp_cfg import vftp_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_FIELD_HEIGHT = 2048,
   parameter int WW = $clog2(MAX_WIDTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata,
   output logic [WW-1:0]     width_sat,
   output logic [THR_W-1:0]  height_sat,
   output band_thr_type      band_thr
);

   logic [CSR_W-1:0]   frame_width_ff;
   logic [11:0]        field_height_ff;
   logic [REC_PW-1:0]  rec_prod;
   logic [THR_W-1:0]   q_in, q_ff, hq_ff;
   logic [THR_W+3:0]   nine_q;
   logic [3:0]         r;
   band_thr_type       thr_in, thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RST;
         field_height_ff <= FIELD_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:  frame_width_ff <= csr_wdata;
            REG_FIELD_HEIGHT: field_height_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_sat = (32'(frame_width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width_ff);
      height_sat = (32'(field_height_ff) > MAX_FIELD_HEIGHT) ?
                   THR_W'(MAX_FIELD_HEIGHT) : THR_W'(field_height_ff);
   end

   // stage a: h/9 by reciprocal
   assign rec_prod = REC_PW'(height_sat) * REC_PW'(REC_M);
   assign q_in = THR_W'(rec_prod >> REC_S);

   // stage b: thresholds k*h/9
   always_comb begin
      nine_q = {1'b0, q_ff, 3'b000} + (THR_W+4)'(q_ff);
      r = 4'(hq_ff - THR_W'(nine_q));
      thr_in.t3 = band_of(q_ff, r, 4'd3);
      thr_in.t4 = band_of(q_ff, r, 4'd4);
      thr_in.t5 = band_of(q_ff, r, 4'd5);
      thr_in.t6 = band_of(q_ff, r, 4'd6);
      thr_in.t8 = band_of(q_ff, r, 4'd8);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      hq_ff <= height_sat;
      thr_ff <= thr_in;
   end

   assign band_thr = thr_ff;

endmodule

@@ rtl/vftp_div.sv @@
// vftp_div: pipelined restoring divider for the bar level x*256/w
// depends on vftp_pkg; numerator must be below the divisor

module vftp_div import vftp_pkg::*; #(
   parameter int WW = 13
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WW-1:0]    num,
   input  logic [WW-1:0]    den,
   output logic [QUO_W-1:0] quo
);

   logic [WW-1:0]    rem_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [WW-1:0]    rem_in [DIV_STAGES];
   logic [QUO_W-1:0] quo_in [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         logic [WW:0]      t;
         logic [WW-1:0]    rem;
         logic [QUO_W-1:0] q;
         if (s == 0) begin
            rem = num;
            q = '0;
         end else begin
            rem = rem_ff[(s == 0) ? 0 : s-1];
            q = quo_ff[(s == 0) ? 0 : s-1];
         end
         for (int b = 0; b < DIV_BITS; b++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, den}) begin
               rem = WW'(t - {1'b0, den});
               q = {q[QUO_W-2:0], 1'b1};
            end else begin
               rem = WW'(t);
               q = {q[QUO_W-2:0], 1'b0};
            end
         end
         rem_in[s] = rem;
         quo_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule
